@@ design/iis_pkg.sv @@
// shared constants for the integral image sum and squared sum block
package iis_pkg;

    localparam int PIXEL_W     = 8;
    localparam int PIXEL_SQ_W  = 2 * PIXEL_W;
    localparam int CFG_W       = 11;
    localparam int AREA_SUM_W  = 28;
    localparam int AREA_SQ_W   = 36;
    localparam int OUT_DATA_W  = AREA_SUM_W + AREA_SQ_W;

    localparam int IIS_MAX_WIDTH  = 1024;
    localparam int IIS_MAX_HEIGHT = 1024;

    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(1024);

    localparam logic [63:0] PIXEL_MAX    = 64'd255;
    localparam logic [63:0] PIXEL_SQ_MAX = 64'd65025;

endpackage

@@ design/integral_image_sum_sqsum.sv @@
// integral image (summed-area table) of a gray pixel stream, sum and squared sum
//
// input channel s_*: one 8-bit pixel per transaction in raster order, s_tuser set on
// the first pixel of a frame. a stream that starts without that flag is taken as a
// frame starting at reset. output channel m_*: one transaction per pixel carrying the
// inclusive summed-area value and the summed-area value of squared pixels, both
// saturating at 255 (65025 squared) times the maximum frame size.
// cfg_we/cfg_wdata set the row width; write it only while the block is idle.
// a width of zero counts as one, a width above MAX_WIDTH as MAX_WIDTH.
// the line store is read synchronously into stage 1 at accept; the add, saturate and
// write back then go from stage 1 into the output register.
// throughput is one pixel per cycle while the receiver is ready; each line store does
// one read and one write a cycle, and a write of the same column read in the same
// cycle is forwarded. when the receiver stalls, the output register holds and the
// pipeline stage behind it still takes a pixel if it is empty, then s_tready drops.
// reset clears the row position and running sums and sets the width to 1024; the
// line stores are not cleared, the first row of a frame never uses their data.
module integral_image_sum_sqsum #(
    parameter int MAX_WIDTH = iis_pkg::IIS_MAX_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [iis_pkg::PIXEL_W-1:0]   s_tdata,    // [7:0] pixel
    input  logic                          s_tuser,    // [0] frame_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [iis_pkg::OUT_DATA_W-1:0] m_tdata,   // [27:0] area_sum, [63:28] area_square_sum
    input  logic                          cfg_we,
    input  logic [iis_pkg::CFG_W-1:0]     cfg_wdata
);

    import iis_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = ((CW + 1) > CFG_W) ? (CW + 1) : CFG_W;
    localparam int RSW  = $clog2(255 * MAX_WIDTH + 1);
    localparam int RQW  = $clog2(65025 * MAX_WIDTH + 1);
    localparam int SUMW = ((RSW > AREA_SUM_W) ? RSW : AREA_SUM_W) + 1;
    localparam int SQW  = ((RQW > AREA_SQ_W) ? RQW : AREA_SQ_W) + 1;

    localparam logic [63:0] SUM_MASK = (64'd1 << AREA_SUM_W) - 64'd1;
    localparam logic [63:0] SQ_MASK  = (64'd1 << AREA_SQ_W) - 64'd1;
    localparam logic [63:0] SUM_FULL = PIXEL_MAX * 64'(MAX_WIDTH) * 64'(IIS_MAX_HEIGHT);
    localparam logic [63:0] SQ_FULL  = PIXEL_SQ_MAX * 64'(MAX_WIDTH) * 64'(IIS_MAX_HEIGHT);
    localparam logic [63:0] SUM_CAP  = (SUM_FULL < SUM_MASK) ? SUM_FULL : SUM_MASK;
    localparam logic [63:0] SQ_CAP   = (SQ_FULL < SQ_MASK) ? SQ_FULL : SQ_MASK;

    // configuration and row state
    logic [CFG_W-1:0]      width_reg;
    logic [CW-1:0]         col_reg, col_next;
    logic [RSW-1:0]        rsum_reg, rsum_next;
    logic [RQW-1:0]        rsq_reg, rsq_next;
    logic                  first_reg, first_next;

    // stage 1: waiting for line store data
    logic                  s1_valid_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [RSW-1:0]        s1_rsum_reg;
    logic [RQW-1:0]        s1_rsq_reg;
    logic                  s1_first_reg;
    logic                  s1_fwd_reg;

    // line stores and their read data
    logic [AREA_SUM_W-1:0] mem_sum [MAX_WIDTH];
    logic [AREA_SQ_W-1:0]  mem_sq  [MAX_WIDTH];
    logic [AREA_SUM_W-1:0] rd_sum_reg;
    logic [AREA_SQ_W-1:0]  rd_sq_reg;

    // last value written, for same-column forwarding
    logic [AREA_SUM_W-1:0] last_sum_reg;
    logic [AREA_SQ_W-1:0]  last_sq_reg;

    // output register
    logic                  out_valid_reg;
    logic [AREA_SUM_W-1:0] out_sum_reg;
    logic [AREA_SQ_W-1:0]  out_sq_reg;

    logic                  s_acc;
    logic                  s1_adv;
    logic [CMPW-1:0]       cfg_ext;
    logic [CMPW-1:0]       w_eff;
    logic                  wrap_pre;
    logic                  row_start;
    logic [CW-1:0]         col_cur;
    logic [CMPW-1:0]       col_inc;
    logic                  row_end;
    logic                  first_cur;
    logic [PIXEL_SQ_W-1:0] px_sq;
    logic [RSW-1:0]        rsum_cur;
    logic [RQW-1:0]        rsq_cur;
    logic                  fwd;

    logic [AREA_SUM_W-1:0] above_sum;
    logic [AREA_SQ_W-1:0]  above_sq;
    logic [SUMW-1:0]       tot_sum;
    logic [SQW-1:0]        tot_sq;
    logic [AREA_SUM_W-1:0] area_sum;
    logic [AREA_SQ_W-1:0]  area_sq;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_acc    = s_tvalid && s_tready;

    // effective row width
    always_comb
    begin
        cfg_ext = CMPW'(width_reg);
        if (cfg_ext == '0)
        begin
            w_eff = CMPW'(1);
        end
        else if (cfg_ext > CMPW'(MAX_WIDTH))
        begin
            w_eff = CMPW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = cfg_ext;
        end
    end

    // column and running row sums for the incoming pixel
    always_comb
    begin
        wrap_pre  = CMPW'(col_reg) >= w_eff;
        row_start = s_tuser || wrap_pre;
        col_cur   = row_start ? '0 : col_reg;
        first_cur = s_tuser ? 1'b1 : (wrap_pre ? 1'b0 : first_reg);
        px_sq     = PIXEL_SQ_W'(s_tdata) * PIXEL_SQ_W'(s_tdata);
        rsum_cur  = (row_start ? '0 : rsum_reg) + RSW'(s_tdata);
        rsq_cur   = (row_start ? '0 : rsq_reg) + RQW'(px_sq);
        col_inc   = CMPW'(col_cur) + CMPW'(1);
        row_end   = col_inc >= w_eff;

        col_next   = row_end ? '0 : col_inc[CW-1:0];
        rsum_next  = row_end ? '0 : rsum_cur;
        rsq_next   = row_end ? '0 : rsq_cur;
        first_next = row_end ? 1'b0 : first_cur;

        // the entry being written back this cycle is the one about to be read
        fwd = s1_adv && (s1_col_reg == col_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            width_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            rsum_reg  <= '0;
            rsq_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (s_acc)
        begin
            col_reg   <= col_next;
            rsum_reg  <= rsum_next;
            rsq_reg   <= rsq_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_col_reg   <= col_cur;
            s1_rsum_reg  <= rsum_cur;
            s1_rsq_reg   <= rsq_cur;
            s1_first_reg <= first_cur;
            s1_fwd_reg   <= fwd;
        end
    end

    // line stores: read at accept, write back when stage 1 moves on
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            mem_sum[s1_col_reg] <= area_sum;
            mem_sq[s1_col_reg]  <= area_sq;
        end
        if (s_acc)
        begin
            rd_sum_reg <= mem_sum[col_cur];
            rd_sq_reg  <= mem_sq[col_cur];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            last_sum_reg <= area_sum;
            last_sq_reg  <= area_sq;
        end
    end

    // add the row above and saturate
    always_comb
    begin
        if (s1_first_reg)
        begin
            above_sum = '0;
            above_sq  = '0;
        end
        else if (s1_fwd_reg)
        begin
            above_sum = last_sum_reg;
            above_sq  = last_sq_reg;
        end
        else
        begin
            above_sum = rd_sum_reg;
            above_sq  = rd_sq_reg;
        end
        tot_sum  = SUMW'(s1_rsum_reg) + SUMW'(above_sum);
        tot_sq   = SQW'(s1_rsq_reg) + SQW'(above_sq);
        area_sum = (64'(tot_sum) >= SUM_CAP) ? SUM_CAP[AREA_SUM_W-1:0]
                                             : tot_sum[AREA_SUM_W-1:0];
        area_sq  = (64'(tot_sq) >= SQ_CAP) ? SQ_CAP[AREA_SQ_W-1:0]
                                           : tot_sq[AREA_SQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_sum_reg <= area_sum;
            out_sq_reg  <= area_sq;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_sq_reg, out_sum_reg};

`ifndef SYNTHESIS
    a_ready_only_when_stage_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_tready |-> s1_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a full pipeline");

    a_frame_start_first_row: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_acc && s_tuser |=> s1_first_reg && (s1_col_reg == '0))
        else $error("frame start did not open row 0 at column 0");

    a_forward_only_column_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_fwd_reg |-> (s1_col_reg == '0))
        else $error("forwarding on a column other than zero");

    a_stage_to_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_adv |=> m_tvalid && (m_tdata[AREA_SUM_W-1:0] == $past(area_sum)))
        else $error("stage 1 result lost on the way to the output");

    a_sum_within_cap: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (64'(out_sum_reg) <= SUM_CAP) && (64'(out_sq_reg) <= SQ_CAP))
        else $error("output above its saturation value");
`endif

endmodule
